// ===== rtl/scgr_pkg.sv =====
// Shared types, constants and helpers for the scaled glyph column renderer.
package scgr_pkg;

  localparam int STORE_BYTES   = 2048;
  localparam int STORE_AW      = $clog2(STORE_BYTES);
  localparam int MAX_GLYPH_DIM = 8;
  localparam int MAX_SCALE     = 8;
  localparam int DIM_W         = 4;
  localparam int COL_W         = (MAX_GLYPH_DIM > 1) ? $clog2(MAX_GLYPH_DIM) : 1;
  localparam int SUB_W         = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int MASK_W        = 64;
  localparam int MASK_IDX_W    = $clog2(MASK_W) + 1;
  localparam int CFG_IDX_W     = 3;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  // character code mapping
  localparam logic [7:0] CODE_SPACE       = 8'd32;
  localparam logic [7:0] CODE_LOWER_FIRST = 8'd97;
  localparam logic [7:0] CODE_LOWER_LAST  = 8'd122;
  localparam logic [7:0] CODE_HIGH_FIRST  = 8'd123;
  localparam logic [7:0] BASE_OFFSET      = 8'd33;
  localparam logic [7:0] LOWER_OFFSET     = 8'd65;
  localparam logic [7:0] HIGH_OFFSET      = 8'd60;

  // register reset values
  localparam logic [7:0]       RST_GLYPH_COUNT  = 8'd0;
  localparam logic [DIM_W-1:0] RST_GLYPH_WIDTH  = 4'd5;
  localparam logic [DIM_W-1:0] RST_GLYPH_HEIGHT = 4'd7;
  localparam logic [DIM_W-1:0] RST_SCALE        = 4'd1;
  localparam logic [7:0]       RST_DRAW_MODE    = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLYPH_COUNT  = 3'd0,
    REG_GLYPH_WIDTH  = 3'd1,
    REG_GLYPH_HEIGHT = 3'd2,
    REG_SCALE        = 3'd3,
    REG_DRAW_MODE    = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_DRAW  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } back_state_e;

  // clamped geometry; the user must keep it static while the block is busy, the block does not enforce it
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] s;
    logic [7:0]       mode;
  } geom_t;

  // one classified transaction; addr is the write address or the glyph base
  typedef struct packed {
    cmd_e                cmd;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
    logic                blank;
    logic [7:0]          x0;
    logic [7:0]          y0;
    logic [7:0]          nx;
  } q_entry_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== rtl/scgr_if.sv =====
// Handshake channel interfaces: draw/load input, column output, register write.
interface scgr_in_if import scgr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [10:0] store_addr;
  logic [7:0]  store_data;
  logic [7:0]  char_code;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;

  modport source (output valid, cmd, store_addr, store_data, char_code, pos_x, pos_y,
                  input ready);
  modport sink   (input valid, cmd, store_addr, store_data, char_code, pos_x, pos_y,
                  output ready);
endinterface

interface scgr_out_if import scgr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [7:0]        pixel_x;
  logic [7:0]        top_y;
  logic [MASK_W-1:0] column_mask;
  logic [7:0]        pixel_mode;
  logic [7:0]        next_x;
  logic              last;

  modport source (output valid, pixel_x, top_y, column_mask, pixel_mode, next_x, last,
                  input ready);
  modport sink   (input valid, pixel_x, top_y, column_mask, pixel_mode, next_x, last,
                  output ready);
endinterface

interface scgr_cfg_if import scgr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/scgr_front.sv =====
// Front end: configuration registers, code mapping and glyph base address.
module scgr_front import scgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  scgr_cfg_if.sink   cfg_i,
  scgr_in_if.sink    in_i,
  input  logic       full_i,
  output logic       push_o,
  output q_entry_t   entry_o,
  output geom_t      geom_o
);

  logic [7:0]       count_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic [DIM_W-1:0] scale_q;
  logic [7:0]       mode_q;

  logic [DIM_W-1:0] w_c;
  logic [DIM_W-1:0] s_c;
  logic [7:0]       idx;
  logic [11:0]      base;
  logic [7:0]       adv;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= RST_GLYPH_COUNT;
      width_q  <= RST_GLYPH_WIDTH;
      height_q <= RST_GLYPH_HEIGHT;
      scale_q  <= RST_SCALE;
      mode_q   <= RST_DRAW_MODE;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_GLYPH_COUNT:  count_q  <= cfg_i.data;
        REG_GLYPH_WIDTH:  width_q  <= cfg_i.data[DIM_W-1:0];
        REG_GLYPH_HEIGHT: height_q <= cfg_i.data[DIM_W-1:0];
        REG_SCALE:        scale_q  <= cfg_i.data[DIM_W-1:0];
        REG_DRAW_MODE:    mode_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign w_c = clamp_dim(width_q, DIM_W'(MAX_GLYPH_DIM));
  assign s_c = clamp_dim(scale_q, DIM_W'(MAX_SCALE));

  assign geom_o.w    = w_c;
  assign geom_o.h    = clamp_dim(height_q, DIM_W'(MAX_GLYPH_DIM));
  assign geom_o.s    = s_c;
  assign geom_o.mode = mode_q;

  // lower case folds onto upper case
  always_comb begin
    if (in_i.char_code >= CODE_LOWER_FIRST && in_i.char_code <= CODE_LOWER_LAST) begin
      idx = in_i.char_code - LOWER_OFFSET;
    end else if (in_i.char_code >= CODE_HIGH_FIRST) begin
      idx = in_i.char_code - HIGH_OFFSET;
    end else begin
      idx = in_i.char_code - BASE_OFFSET;
    end
  end

  assign base = {8'd0, w_c} * {4'd0, idx};
  assign adv  = 8'(({4'd0, w_c} + 8'd1) * {4'd0, s_c});

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    entry_o.cmd   = cmd_e'(in_i.cmd);
    entry_o.addr  = (cmd_e'(in_i.cmd) == CMD_DRAW) ? STORE_AW'(base)
                                                   : STORE_AW'(in_i.store_addr);
    entry_o.data  = in_i.store_data;
    entry_o.blank = (in_i.char_code <= CODE_SPACE) || (idx >= count_q);
    entry_o.x0    = in_i.pos_x;
    entry_o.y0    = in_i.pos_y;
    entry_o.nx    = in_i.pos_x + adv;
  end

endmodule

// ===== rtl/scgr_fifo.sv =====
// Short queue between the front end and the column sequencer.
module scgr_fifo import scgr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output q_entry_t entry_o
);

  q_entry_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QPTR_W:0]     fill_q;

  assign full_o  = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push_i && !pop_i)      fill_q <= fill_q + (QPTR_W+1)'(1);
      else if (pop_i && !push_i) fill_q <= fill_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= entry_i;
  end

endmodule

// ===== rtl/scgr_back.sv =====
// Back end: glyph store and column sequencer with registered output.
module scgr_back import scgr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  geom_t     geom_i,
  input  logic      q_valid_i,
  input  q_entry_t  q_entry_i,
  output logic      q_pop_o,
  scgr_out_if.source out_o
);

  back_state_e state_q, state_d;

  logic [7:0]          mem_q [STORE_BYTES];
  logic [7:0]          rdata_q;

  logic [STORE_AW-1:0] base_q;
  logic                blank_q;
  logic [7:0]          x_q;
  logic [7:0]          y_q;
  logic [7:0]          nx_q;
  logic [COL_W-1:0]    gc_q;
  logic [SUB_W-1:0]    sub_q;

  logic                ov_q;
  logic [7:0]          px_q;
  logic [7:0]          ty_q;
  logic [MASK_W-1:0]   mask_q;
  logic [7:0]          pm_q;
  logic [7:0]          nxo_q;
  logic                last_q;

  logic                mem_we;
  logic                rd_en;
  logic                load_draw;
  logic                emit;
  logic                sub_last;
  logic                col_last;
  logic [MASK_W-1:0]   mask_c;

  assign sub_last = ({{(DIM_W-SUB_W){1'b0}}, sub_q} == geom_i.s - DIM_W'(1));
  assign col_last = ({{(DIM_W-COL_W){1'b0}}, gc_q} == geom_i.w - DIM_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    load_draw = 1'b0;
    emit      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_entry_i.cmd == CMD_WRITE) begin
            mem_we = 1'b1;
          end else begin
            load_draw = 1'b1;
            state_d   = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ov_q || out_o.ready) begin
          emit = 1'b1;
          if (sub_last) state_d = col_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // glyph store, one byte per glyph column
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[q_entry_i.addr] <= q_entry_i.data;
    if (rd_en)  rdata_q <= mem_q[base_q + STORE_AW'(gc_q)];
  end

  always_ff @(posedge clk_i) begin
    if (load_draw) begin
      base_q  <= q_entry_i.addr;
      blank_q <= q_entry_i.blank;
      x_q     <= q_entry_i.x0;
      y_q     <= q_entry_i.y0;
      nx_q    <= q_entry_i.nx;
      gc_q    <= '0;
      sub_q   <= '0;
    end else if (emit) begin
      x_q <= x_q + 8'd1;
      if (sub_last) begin
        sub_q <= '0;
        gc_q  <= gc_q + COL_W'(1);
      end else begin
        sub_q <= sub_q + SUB_W'(1);
      end
    end
  end

  // row r of the glyph covers mask bits r*s .. r*s+s-1
  always_comb begin
    logic [MASK_IDX_W-1:0] lo;
    logic [MASK_IDX_W-1:0] hi;
    mask_c = '0;
    for (int j = 0; j < MASK_W; j++) begin
      for (int r = 0; r < MAX_GLYPH_DIM; r++) begin
        lo = MASK_IDX_W'(r) * MASK_IDX_W'(geom_i.s);
        hi = lo + MASK_IDX_W'(geom_i.s);
        if (MASK_IDX_W'(j) >= lo && MASK_IDX_W'(j) < hi && DIM_W'(r) < geom_i.h) begin
          mask_c[j] = rdata_q[r];
        end
      end
    end
    if (blank_q) mask_c = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)           ov_q <= 1'b0;
    else if (emit)         ov_q <= 1'b1;
    else if (out_o.ready)  ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q   <= x_q;
      ty_q   <= y_q;
      mask_q <= mask_c;
      pm_q   <= geom_i.mode;
      nxo_q  <= nx_q;
      last_q <= sub_last && col_last;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.pixel_x     = px_q;
  assign out_o.top_y       = ty_q;
  assign out_o.column_mask = mask_q;
  assign out_o.pixel_mode  = pm_q;
  assign out_o.next_x      = nxo_q;
  assign out_o.last        = last_q;

endmodule

// ===== rtl/scaled_glyph_column_renderer.sv =====
// Top level of the scaled glyph column renderer.
// Channels: in_i takes load transactions (cmd 0: store_data at store_addr)
// and draw transactions (cmd 1: char_code at pos_x/pos_y). out_o returns one
// transaction per scaled glyph column, left to right, with last set on the
// final column of a character. cfg_i writes the five geometry/mode registers
// and is always ready; write it only while the block is idle.
// The front end classifies each input and queues it (two entries), so in_i
// keeps accepting while the column sequencer works or the output stalls.
// Pacing: a load is written to the glyph store in the idle state; a draw
// passes the idle state, then per glyph column one glyph store read (READ)
// and s columns at one per cycle while out_o does not stall (EMIT). A new
// queue entry is taken only when idle. An accepted draw is queued, popped,
// read from the glyph store and then registered into out_o.
// A stalled out_o holds its register and the sequencer waits; the queue
// then fills and in_i drops ready.
// Reset restores the register defaults and empties the queue and output;
// the glyph store is not cleared and must be loaded before drawing.
module scaled_glyph_column_renderer import scgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  scgr_cfg_if.sink   cfg_i,
  scgr_in_if.sink    in_i,
  scgr_out_if.source out_o
);

  logic     push;
  logic     full;
  logic     q_valid;
  logic     q_pop;
  q_entry_t entry_in;
  q_entry_t entry_out;
  geom_t    geom;

  scgr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry_in),
    .geom_o  (geom)
  );

  scgr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (entry_out)
  );

  scgr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .geom_i    (geom),
    .q_valid_i (q_valid),
    .q_entry_i (entry_out),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
